@@ rtl/core/stt_pkg.sv @@
// Shared opcodes and sizing constants for the software timer table.
package stt_pkg;

   localparam int DEFAULT_TIMER_SLOTS = 8;
   localparam int MaxResults = 8;
   localparam int OpcodeW = 3;
   localparam int SlotW = 3;
   localparam int WordW = 32;

   localparam logic [OpcodeW-1:0] OP_TICK       = 3'd0;
   localparam logic [OpcodeW-1:0] OP_REGISTER   = 3'd1;
   localparam logic [OpcodeW-1:0] OP_UNREGISTER = 3'd2;
   localparam logic [OpcodeW-1:0] OP_CLEAR      = 3'd3;
   localparam logic [OpcodeW-1:0] OP_PROCESS    = 3'd4;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

endpackage

@@ rtl/core/stt_slot_mem.sv @@
// Slot memory: one write port, one read port with registered read data.
module stt_slot_mem #(
   parameter int Depth = stt_pkg::DEFAULT_TIMER_SLOTS,
   parameter int AddrW = 3,
   parameter int DataW = 64
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [DataW-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [DataW-1:0] rd_data
);
   import stt_pkg::*;

   logic [DataW-1:0] mem_ff [Depth];
   logic [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/software_timer_table.sv @@
// Software timer table top level: slot allocation and release, tick, and expiry scan.
//
// A command is taken when start is high and busy is low. Tick, unregister,
// clear and undefined opcodes finish in the accepting cycle and never raise
// busy; their single result appears on the following cycle. Register walks
// the active flags one slot per cycle from slot 0 and claims the lowest
// inactive slot. Process reads one slot per cycle through the single read
// port of the slot memory; it returns one result per expired slot (at most
// eight, the last one marked) or one "none fired" result. Results are shown
// for exactly one cycle under rsp_strobe and the receiver cannot stall them.
// Each slot keeps the millisecond stamp of its last restart, so a tick only
// advances the millisecond count and reset needs no pass over the memory.
module software_timer_table #(
   parameter int TimerSlots = stt_pkg::DEFAULT_TIMER_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [stt_pkg::OpcodeW-1:0] req_opcode,
   input  logic [stt_pkg::WordW-1:0]   req_period,
   input  logic [stt_pkg::SlotW-1:0]   req_timer_id,
   input  logic [stt_pkg::WordW-1:0]   req_user_value,
   output logic                        rsp_strobe,
   output logic                        rsp_status,
   output logic [stt_pkg::SlotW-1:0]   rsp_slot,
   output logic                        rsp_fired,
   output logic [stt_pkg::WordW-1:0]   rsp_passed_value,
   output logic [stt_pkg::WordW-1:0]   rsp_ms_count,
   output logic                        rsp_last
);
   import stt_pkg::*;

   localparam int IdxW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
   localparam int CntW = $clog2(TimerSlots + 1);
   localparam int FireW = $clog2(MaxResults + 1);
   localparam int MemW = 2 * WordW;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REG  = 2'd1;
   localparam logic [1:0] ST_PROC = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [TimerSlots-1:0] active_ff, active_in;
   logic [WordW-1:0]      ms_ff, ms_in;
   logic [WordW-1:0]      period_ff, period_in;
   logic [WordW-1:0]      uval_ff, uval_in;
   logic [IdxW-1:0]       reg_idx_ff, reg_idx_in;
   logic [CntW-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic [IdxW-1:0]       eval_idx_ff, eval_idx_in;
   logic [FireW-1:0]      fire_cnt_ff, fire_cnt_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [IdxW-1:0]       pend_slot_ff, pend_slot_in;

   logic                  strobe_ff, strobe_in;
   logic                  status_ff, status_in;
   logic [SlotW-1:0]      slot_ff, slot_in;
   logic                  fired_ff, fired_in;
   logic [WordW-1:0]      passed_ff, passed_in;
   logic                  last_ff, last_in;

   logic                  mem_wr_en;
   logic [IdxW-1:0]       mem_wr_addr;
   logic [MemW-1:0]       mem_wr_data;
   logic                  mem_rd_en;
   logic [IdxW-1:0]       mem_rd_addr;
   logic [MemW-1:0]       mem_rd_data;

   logic                  accept;
   logic                  tid_ok;
   logic [IdxW-1:0]       tid_idx;
   logic [WordW-1:0]      rd_stamp;
   logic [WordW-1:0]      rd_period;
   logic [WordW-1:0]      elapsed;
   logic                  due;
   logic                  scan_done;

   stt_slot_mem #(
      .Depth (TimerSlots),
      .AddrW (IdxW),
      .DataW (MemW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign tid_ok  = (32'(req_timer_id) < 32'(TimerSlots));
   assign tid_idx = IdxW'(req_timer_id);

   // Memory word: period in the upper half, restart stamp in the lower half.
   assign rd_period = mem_rd_data[MemW-1:WordW];
   assign rd_stamp  = mem_rd_data[WordW-1:0];
   assign elapsed   = ms_ff - rd_stamp;
   assign due       = active_ff[eval_idx_ff] && (elapsed >= rd_period);

   assign scan_done = (fire_cnt_ff == FireW'(MaxResults)) ||
                      ((rd_cnt_ff == CntW'(TimerSlots)) && !eval_valid_ff);

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      ms_in         = ms_ff;
      period_in     = period_ff;
      uval_in       = uval_ff;
      reg_idx_in    = reg_idx_ff;
      rd_cnt_in     = rd_cnt_ff;
      eval_valid_in = 1'b0;
      eval_idx_in   = eval_idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;

      strobe_in = 1'b0;
      status_in = STATUS_OK;
      slot_in   = '0;
      fired_in  = 1'b0;
      passed_in = '0;
      last_in   = 1'b1;

      mem_wr_en   = 1'b0;
      mem_wr_addr = reg_idx_ff;
      mem_wr_data = {period_ff, ms_ff};
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_cnt_ff[IdxW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               period_in = req_period;
               uval_in   = req_user_value;
               unique case (req_opcode)
                  OP_TICK: begin
                     ms_in     = ms_ff + 1'b1;
                     strobe_in = 1'b1;
                  end
                  OP_REGISTER: begin
                     reg_idx_in = '0;
                     state_in   = ST_REG;
                  end
                  OP_UNREGISTER: begin
                     strobe_in = 1'b1;
                     slot_in   = req_timer_id;
                     if (tid_ok && active_ff[tid_idx]) begin
                        active_in[tid_idx] = 1'b0;
                     end else begin
                        status_in = STATUS_ERR;
                     end
                  end
                  OP_CLEAR: begin
                     active_in = '0;
                     strobe_in = 1'b1;
                  end
                  OP_PROCESS: begin
                     rd_cnt_in     = '0;
                     fire_cnt_in   = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_PROC;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = STATUS_ERR;
                  end
               endcase
            end
         end
         ST_REG: begin
            // Claim the lowest inactive slot; restart its stamp now.
            if (!active_ff[reg_idx_ff]) begin
               active_in[reg_idx_ff] = 1'b1;
               mem_wr_en = 1'b1;
               strobe_in = 1'b1;
               slot_in   = SlotW'(reg_idx_ff);
               state_in  = ST_IDLE;
            end else if (reg_idx_ff == IdxW'(TimerSlots - 1)) begin
               strobe_in = 1'b1;
               status_in = STATUS_ERR;
               state_in  = ST_IDLE;
            end else begin
               reg_idx_in = reg_idx_ff + 1'b1;
            end
         end
         ST_PROC: begin
            if (scan_done) begin
               strobe_in = 1'b1;
               if (pend_valid_ff) begin
                  slot_in   = SlotW'(pend_slot_ff);
                  fired_in  = 1'b1;
                  passed_in = uval_ff;
               end
               state_in = ST_IDLE;
            end else begin
               if (rd_cnt_ff != CntW'(TimerSlots)) begin
                  mem_rd_en     = 1'b1;
                  rd_cnt_in     = rd_cnt_ff + 1'b1;
                  eval_valid_in = 1'b1;
                  eval_idx_in   = rd_cnt_ff[IdxW-1:0];
               end
               // Hold each fired slot until the next one fires or the scan ends, so the final beat can carry last.
               if (eval_valid_ff && due) begin
                  mem_wr_en     = 1'b1;
                  mem_wr_addr   = eval_idx_ff;
                  mem_wr_data   = {rd_period, ms_ff};
                  fire_cnt_in   = fire_cnt_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_slot_in  = eval_idx_ff;
                  if (pend_valid_ff) begin
                     strobe_in = 1'b1;
                     slot_in   = SlotW'(pend_slot_ff);
                     fired_in  = 1'b1;
                     passed_in = uval_ff;
                     last_in   = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         ms_ff         <= '0;
         strobe_ff     <= 1'b0;
         eval_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         ms_ff         <= ms_in;
         strobe_ff     <= strobe_in;
         eval_valid_ff <= eval_valid_in;
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      period_ff    <= period_in;
      uval_ff      <= uval_in;
      reg_idx_ff   <= reg_idx_in;
      eval_idx_ff  <= eval_idx_in;
      pend_slot_ff <= pend_slot_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      fired_ff     <= fired_in;
      passed_ff    <= passed_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_fired        = fired_ff;
   assign rsp_passed_value = passed_ff;
   assign rsp_ms_count     = ms_ff;
   assign rsp_last         = last_ff;

endmodule

@@ verif/stt_checker.sv @@
// Timer table checker: predicts every command beat's results and compares the result beats.
module stt_checker #(
   parameter int TimerSlots = stt_pkg::DEFAULT_TIMER_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [stt_pkg::OpcodeW-1:0] req_opcode,
   input  logic [stt_pkg::WordW-1:0]   req_period,
   input  logic [stt_pkg::SlotW-1:0]   req_timer_id,
   input  logic [stt_pkg::WordW-1:0]   req_user_value,
   input  logic                        rsp_strobe,
   input  logic                        rsp_status,
   input  logic [stt_pkg::SlotW-1:0]   rsp_slot,
   input  logic                        rsp_fired,
   input  logic [stt_pkg::WordW-1:0]   rsp_passed_value,
   input  logic [stt_pkg::WordW-1:0]   rsp_ms_count,
   input  logic                        rsp_last,
   output int                          fail_count,
   output int                          pending
);
   import stt_pkg::*;

   typedef struct packed {
      logic             status;
      logic [SlotW-1:0] slot;
      logic             fired;
      logic [WordW-1:0] passed_value;
      logic [WordW-1:0] ms_count;
      logic             last;
   } timer_result_type;

   logic [WordW-1:0] ms_now;
   logic [WordW-1:0] elapsed [TimerSlots];
   logic [WordW-1:0] interval [TimerSlots];
   logic             armed [TimerSlots];
   timer_result_type awaited [$];
   int               mismatches = 0;
   int               outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   function automatic timer_result_type beat_of(input logic status, input int slot,
                                                input logic fired,
                                                input logic [WordW-1:0] value);
      timer_result_type r;
      r.status       = status;
      r.slot         = SlotW'(slot);
      r.fired        = fired;
      r.passed_value = value;
      r.ms_count     = ms_now;
      r.last         = 1'b0;
      return r;
   endfunction

   function automatic void clear_slots();
      for (int i = 0; i < TimerSlots; i++) begin
         armed[i]    = 1'b0;
         elapsed[i]  = '0;
         interval[i] = '0;
      end
   endfunction

   function automatic void predict_command(input logic [OpcodeW-1:0] op,
                                           input logic [WordW-1:0] per,
                                           input logic [SlotW-1:0] tid,
                                           input logic [WordW-1:0] uval);
      timer_result_type batch [$];
      int               free_slot;
      free_slot = -1;
      case (op)
         OP_TICK: begin
            ms_now = ms_now + 1'b1;
            for (int i = 0; i < TimerSlots; i++)
               if (armed[i]) elapsed[i] = elapsed[i] + 1'b1;
            batch.push_back(beat_of(STATUS_OK, 0, 1'b0, '0));
         end
         OP_REGISTER: begin
            // walk down so the lowest free slot wins
            for (int i = TimerSlots - 1; i >= 0; i--)
               if (!armed[i]) free_slot = i;
            if (free_slot < 0) begin
               batch.push_back(beat_of(STATUS_ERR, 0, 1'b0, '0));
            end else begin
               armed[free_slot]    = 1'b1;
               elapsed[free_slot]  = '0;
               interval[free_slot] = per;
               batch.push_back(beat_of(STATUS_OK, free_slot, 1'b0, '0));
            end
         end
         OP_UNREGISTER: begin
            if (int'(tid) < TimerSlots && armed[tid]) begin
               armed[tid]    = 1'b0;
               elapsed[tid]  = '0;
               interval[tid] = '0;
               batch.push_back(beat_of(STATUS_OK, int'(tid), 1'b0, '0));
            end else begin
               batch.push_back(beat_of(STATUS_ERR, int'(tid), 1'b0, '0));
            end
         end
         OP_CLEAR: begin
            clear_slots();
            batch.push_back(beat_of(STATUS_OK, 0, 1'b0, '0));
         end
         OP_PROCESS: begin
            for (int i = 0; i < TimerSlots && batch.size() < MaxResults; i++) begin
               if (armed[i] && elapsed[i] >= interval[i]) begin
                  elapsed[i] = '0;
                  batch.push_back(beat_of(STATUS_OK, i, 1'b1, uval));
               end
            end
            if (batch.size() == 0) batch.push_back(beat_of(STATUS_OK, 0, 1'b0, '0));
         end
         default: begin
            batch.push_back(beat_of(STATUS_ERR, 0, 1'b0, '0));
         end
      endcase
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) awaited.push_back(batch[k]);
   endfunction

   function automatic void check_field(input string name, input logic [WordW-1:0] want,
                                       input logic [WordW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         ms_now = '0;
         clear_slots();
         awaited.delete();
      end else begin
         // retire the result beat first; it always belongs to an older command
         if (rsp_strobe) begin
            if (awaited.size() == 0) begin
               $error("result beat with nothing awaited: slot %0d fired %0b", rsp_slot,
                      rsp_fired);
               mismatches++;
            end else begin
               want = awaited.pop_front();
               check_field("status", WordW'(want.status), WordW'(rsp_status));
               check_field("slot", WordW'(want.slot), WordW'(rsp_slot));
               check_field("fired", WordW'(want.fired), WordW'(rsp_fired));
               check_field("passed_value", want.passed_value, rsp_passed_value);
               check_field("ms_count", want.ms_count, rsp_ms_count);
               check_field("last", WordW'(want.last), WordW'(rsp_last));
            end
         end
         if (start && !busy)
            predict_command(req_opcode, req_period, req_timer_id, req_user_value);
      end
      outstanding = awaited.size();
   end

endmodule

@@ verif/tb_software_timer_table.sv @@
// Testbench top for the software timer table: clock, reset, command stimulus and verdict.
module tb_software_timer_table;
   import stt_pkg::*;

   localparam int SLOTS       = DEFAULT_TIMER_SLOTS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_CMDS = 100;

   localparam logic [OpcodeW-1:0] OP_UNDEF_LO  = 3'd5;
   localparam logic [OpcodeW-1:0] OP_UNDEF_MID = 3'd6;
   localparam logic [OpcodeW-1:0] OP_UNDEF_HI  = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OpcodeW-1:0] req_opcode = '0;
   logic [WordW-1:0]   req_period = '0;
   logic [SlotW-1:0]   req_timer_id = '0;
   logic [WordW-1:0]   req_user_value = '0;
   logic               rsp_strobe;
   logic               rsp_status;
   logic [SlotW-1:0]   rsp_slot;
   logic               rsp_fired;
   logic [WordW-1:0]   rsp_passed_value;
   logic [WordW-1:0]   rsp_ms_count;
   logic               rsp_last;
   int                 fail_count;
   int                 pending;
   int                 cycles = 0;
   logic               burst = 1'b0;

   always #10 clock = ~clock;

   software_timer_table #(.TimerSlots(SLOTS)) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_period       (req_period),
      .req_timer_id     (req_timer_id),
      .req_user_value   (req_user_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_fired        (rsp_fired),
      .rsp_passed_value (rsp_passed_value),
      .rsp_ms_count     (rsp_ms_count),
      .rsp_last         (rsp_last)
   );

   stt_checker #(.TimerSlots(SLOTS)) u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_period       (req_period),
      .req_timer_id     (req_timer_id),
      .req_user_value   (req_user_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_fired        (rsp_fired),
      .rsp_passed_value (rsp_passed_value),
      .rsp_ms_count     (rsp_ms_count),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic issue_command(input logic [OpcodeW-1:0] op, input logic [WordW-1:0] per,
                                input logic [SlotW-1:0] tid, input logic [WordW-1:0] uval);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_period     <= per;
      req_timer_id   <= tid;
      req_user_value <= uval;
      // busy only moves at rising edges, so its value here holds at the next one
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Mostly short periods so timers fire often; now and then a wide one.
   function automatic logic [WordW-1:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return '1;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   initial begin
      int pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      issue_command(OP_PROCESS, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_UNDEF_LO, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_UNDEF_MID, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_UNDEF_HI, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_UNREGISTER, $urandom, 3'd7, $urandom);
      issue_command(OP_REGISTER, '0, SlotW'($urandom), $urandom);
      issue_command(OP_REGISTER, '1, SlotW'($urandom), $urandom);
      for (int p = 1; p <= SLOTS - 2; p++)
         issue_command(OP_REGISTER, WordW'(p), SlotW'($urandom), $urandom);
      // table is full now
      issue_command(OP_REGISTER, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_TICK, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_PROCESS, $urandom, SlotW'($urandom), '1);
      repeat (5) issue_command(OP_TICK, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_PROCESS, $urandom, SlotW'($urandom), '0);
      issue_command(OP_UNREGISTER, $urandom, 3'd3, $urandom);
      issue_command(OP_UNREGISTER, $urandom, 3'd3, $urandom);
      issue_command(OP_REGISTER, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_CLEAR, $urandom, SlotW'($urandom), $urandom);
      issue_command(OP_PROCESS, $urandom, SlotW'($urandom), $urandom);

      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 12 == 0) burst = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 36)
            issue_command(OP_TICK, $urandom, SlotW'($urandom), $urandom);
         else if (pick < 58)
            issue_command(OP_PROCESS, $urandom, SlotW'($urandom), $urandom);
         else if (pick < 76)
            issue_command(OP_REGISTER, pick_period(), SlotW'($urandom), $urandom);
         else if (pick < 91)
            issue_command(OP_UNREGISTER, $urandom, SlotW'($urandom), $urandom);
         else if (pick < 94)
            issue_command(OP_CLEAR, $urandom, SlotW'($urandom), $urandom);
         else
            issue_command(OpcodeW'(OP_UNDEF_LO + $urandom_range(0, 2)), $urandom,
                          SlotW'($urandom), $urandom);
      end
      start <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (SLOTS + 4) @(posedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ software_timer_table.f @@
rtl/core/stt_pkg.sv
rtl/core/stt_slot_mem.sv
rtl/core/software_timer_table.sv
verif/stt_checker.sv
verif/tb_software_timer_table.sv
